// File: design/pwti_pkg.sv
// shared types and constants for the pinhole projection block
`default_nettype none
package pwti_pkg;
   localparam int NumRegs     = 6;
   localparam int CsrIdxWidth = 3;
   // divider datapath width, holds the scaled denominator for fraction widths of 16 and up
   localparam int DivWidth    = 80;
   // integer and fraction quotient bits together, one cell per bit
   localparam int DivSteps    = 32;

   localparam logic [1:0] StatusOk        = 2'd0;
   localparam logic [1:0] StatusZeroDepth = 2'd1;
   localparam logic [1:0] StatusSaturated = 2'd2;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic [1:0]         status;
   } rsp_word_type;

   // one step of the shared division chain, numerators and remainders
   typedef struct packed {
      logic                valid;
      logic                zero;
      logic                over_u;
      logic                over_v;
      logic                neg_u;
      logic                neg_v;
      logic [DivWidth-1:0] den;
      logic [DivWidth-1:0] rem_u;
      logic [DivWidth-1:0] rem_v;
      logic [63:0]         quo_u;
      logic [63:0]         quo_v;
   } div_cell_type;
endpackage
`default_nettype wire

// File: design/pinhole_world_to_image_top.sv
// top level of the pinhole world to image projection pipeline
//
// channel  dir  handshake            word
// req      in   req_valid/req_ready  pwti_pkg::req_word_type (world_x, world_y, world_z)
// rsp      out  rsp_valid/rsp_ready  pwti_pkg::rsp_word_type (pixel_u, pixel_v, status)
// csr      in   csr_valid/csr_ready  csr_index, csr_data (64-bit row register)
//
// one word per cycle sustained unless the output is stalled by rsp_ready
// path: input register, coefficient multiply, row sum, range check head,
// then a chain of 32 divider cells (integer and fraction quotient bits), then result
// the whole pipe advances when the output register is empty or being drained
// reset clears valid bits and all six row registers to zero
`default_nettype none
module pinhole_world_to_image_top #(
   parameter int FRAC_BITS   = 16,
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire pwti_pkg::req_word_type       req_word,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output pwti_pkg::rsp_word_type            rsp_word,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [pwti_pkg::CsrIdxWidth-1:0] csr_index,
   input  wire logic [63:0]                  csr_data
);
   logic [63:0] regs_ff [pwti_pkg::NumRegs];
   logic        adv;   // whole pipe moves
   logic [2:0]  vld_ff;  // valid of input, product and sum stages
   logic signed [31:0] px, py, pz;
   logic signed [63:0] acc_u, acc_v, acc_d;
   pwti_pkg::div_cell_type head_ff, head_in;
   pwti_pkg::div_cell_type chain [pwti_pkg::DivSteps+1];
   pwti_pkg::rsp_word_type out_ff, out_in;
   logic out_vld_ff;
   logic [63:0] mu, mv, md;
   logic [pwti_pkg::DivWidth-1:0] nu, nv, dd, lim;
   logic [63:0] mag_u, mag_v;
   pwti_pkg::req_word_type in_ff;

   assign csr_ready = 1'b1;
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   // row registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwti_pkg::NumRegs; i++) regs_ff[i] <= '0;
      end else if (csr_valid && csr_index < 3'(pwti_pkg::NumRegs)) begin
         regs_ff[csr_index] <= csr_data;
      end
   end

   // input register, coordinates sign extended from COORD_WIDTH
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], req_valid};
      end
      if (adv) in_ff <= req_word;
   end
   assign px = 32'($signed(in_ff.world_x[COORD_WIDTH-1:0]));
   assign py = 32'($signed(in_ff.world_y[COORD_WIDTH-1:0]));
   assign pz = 32'($signed(in_ff.world_z[COORD_WIDTH-1:0]));

   pwti_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_u (.clock, .en(adv),
      .reg_a(regs_ff[0]), .reg_b(regs_ff[1]), .px, .py, .pz, .acc(acc_u));
   pwti_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_v (.clock, .en(adv),
      .reg_a(regs_ff[2]), .reg_b(regs_ff[3]), .px, .py, .pz, .acc(acc_v));
   pwti_dot #(.FRAC_BITS(FRAC_BITS)) u_dot_d (.clock, .en(adv),
      .reg_a(regs_ff[4]), .reg_b(regs_ff[5]), .px, .py, .pz, .acc(acc_d));

   // magnitudes and integer range check, shared denominator
   // the integer part is too big when n >= (2^(31-FRAC_BITS) + 1) * d
   // otherwise n < d << (32-FRAC_BITS), so 32 restore steps give n * 2^FRAC_BITS / d
   always_comb begin
      mu = acc_u[63] ? 64'(-acc_u) : 64'(acc_u);
      mv = acc_v[63] ? 64'(-acc_v) : 64'(acc_v);
      md = acc_d[63] ? 64'(-acc_d) : 64'(acc_d);
      nu = {{(pwti_pkg::DivWidth-64){1'b0}}, mu};
      nv = {{(pwti_pkg::DivWidth-64){1'b0}}, mv};
      dd = {{(pwti_pkg::DivWidth-64){1'b0}}, md};
      lim = (dd << (31 - FRAC_BITS)) + dd;
      head_in.valid  = vld_ff[2];
      head_in.zero   = (acc_d == '0);
      head_in.neg_u  = acc_u[63] ^ acc_d[63];
      head_in.neg_v  = acc_v[63] ^ acc_d[63];
      head_in.over_u = (nu >= lim);
      head_in.over_v = (nv >= lim);
      head_in.den    = dd << (32 - FRAC_BITS);
      head_in.quo_u  = '0;
      head_in.quo_v  = '0;
      head_in.rem_u  = nu;
      head_in.rem_v  = nv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (adv) begin
         head_ff.valid <= head_in.valid;
      end
      if (adv) begin
         head_ff.zero   <= head_in.zero;
         head_ff.neg_u  <= head_in.neg_u;
         head_ff.neg_v  <= head_in.neg_v;
         head_ff.over_u <= head_in.over_u;
         head_ff.over_v <= head_in.over_v;
         head_ff.den    <= head_in.den;
         head_ff.quo_u  <= head_in.quo_u;
         head_ff.quo_v  <= head_in.quo_v;
         head_ff.rem_u  <= head_in.rem_u;
         head_ff.rem_v  <= head_in.rem_v;
      end
   end

   // quotient bits, one cell per bit
   assign chain[0] = head_ff;
   for (genvar g = 0; g < pwti_pkg::DivSteps; g++) begin : g_cell
      pwti_div_cell u_cell (.clock, .reset, .en(adv),
         .cell_i(chain[g]), .cell_o(chain[g+1]));
   end

   // range check and sign, into output register
   always_comb begin
      pwti_pkg::div_cell_type t;
      logic su, sv;
      t = chain[pwti_pkg::DivSteps];
      mag_u = t.neg_u ? 64'h8000_0000 : 64'h7FFF_FFFF;
      mag_v = t.neg_v ? 64'h8000_0000 : 64'h7FFF_FFFF;
      su = t.over_u || t.quo_u > mag_u;
      sv = t.over_v || t.quo_v > mag_v;
      out_in.pixel_u = su ? 32'(mag_u) : (t.neg_u ? 32'(-t.quo_u) : t.quo_u[31:0]);
      out_in.pixel_v = sv ? 32'(mag_v) : (t.neg_v ? 32'(-t.quo_v) : t.quo_v[31:0]);
      out_in.status  = (su || sv) ? pwti_pkg::StatusSaturated : pwti_pkg::StatusOk;
      if (t.zero) begin
         out_in.pixel_u = '0;
         out_in.pixel_v = '0;
         out_in.status  = pwti_pkg::StatusZeroDepth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= chain[pwti_pkg::DivSteps].valid;
      end
      if (adv) out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

   // a held result does not change while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result changed while stalled");
   // zero depth always reports zero pixels
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == pwti_pkg::StatusZeroDepth |->
      rsp_word.pixel_u == '0 && rsp_word.pixel_v == '0)
      else $error("zero depth with nonzero pixels");
   // input stall only when output is blocked
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without backpressure");
endmodule
`default_nettype wire

// File: design/pwti_dot.sv
// pipelined dot product of one projection row with a world point
`default_nettype none
module pwti_dot #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [63:0]        reg_a,
   input  wire logic [63:0]        reg_b,
   input  wire logic signed [31:0] px,
   input  wire logic signed [31:0] py,
   input  wire logic signed [31:0] pz,
   output logic signed [63:0]      acc
);
   logic signed [63:0] mx_ff, my_ff, mz_ff, mx_in, my_in, mz_in;
   logic signed [31:0] t_ff;
   logic signed [63:0] acc_ff, acc_in;

   assign mx_in = $signed(reg_a[31:0]) * px;
   assign my_in = $signed(reg_a[63:32]) * py;
   assign mz_in = $signed(reg_b[31:0]) * pz;
   // arithmetic shift floors, as the alignment needs
   assign acc_in = (mx_ff >>> FRAC_BITS) + (my_ff >>> FRAC_BITS) + (mz_ff >>> FRAC_BITS)
                 + 64'(t_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff  <= mx_in;
         my_ff  <= my_in;
         mz_ff  <= mz_in;
         t_ff   <= $signed(reg_b[63:32]);
         acc_ff <= acc_in;
      end
   end
   assign acc = acc_ff;
endmodule
`default_nettype wire

// File: design/pwti_div_cell.sv
// one cell of the divider chain: restore step on both quotients
`default_nettype none
module pwti_div_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire pwti_pkg::div_cell_type cell_i,
   output pwti_pkg::div_cell_type      cell_o
);
   pwti_pkg::div_cell_type cell_ff, cell_in;
   logic [pwti_pkg::DivWidth:0] ru, rv, du, dv;

   always_comb begin
      cell_in = cell_i;
      ru = {cell_i.rem_u, 1'b0};
      rv = {cell_i.rem_v, 1'b0};
      du = ru - {1'b0, cell_i.den};
      dv = rv - {1'b0, cell_i.den};
      cell_in.quo_u = {cell_i.quo_u[62:0], 1'b0};
      cell_in.quo_v = {cell_i.quo_v[62:0], 1'b0};
      cell_in.rem_u = ru[pwti_pkg::DivWidth-1:0];
      cell_in.rem_v = rv[pwti_pkg::DivWidth-1:0];
      if (ru >= {1'b0, cell_i.den}) begin
         cell_in.rem_u = du[pwti_pkg::DivWidth-1:0];
         cell_in.quo_u[0] = 1'b1;
      end
      if (rv >= {1'b0, cell_i.den}) begin
         cell_in.rem_v = dv[pwti_pkg::DivWidth-1:0];
         cell_in.quo_v[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (en) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (en) begin
         cell_ff.zero   <= cell_in.zero;
         cell_ff.over_u <= cell_in.over_u;
         cell_ff.over_v <= cell_in.over_v;
         cell_ff.neg_u  <= cell_in.neg_u;
         cell_ff.neg_v  <= cell_in.neg_v;
         cell_ff.den    <= cell_in.den;
         cell_ff.rem_u  <= cell_in.rem_u;
         cell_ff.rem_v  <= cell_in.rem_v;
         cell_ff.quo_u  <= cell_in.quo_u;
         cell_ff.quo_v  <= cell_in.quo_v;
      end
   end
   assign cell_o = cell_ff;
endmodule
`default_nettype wire

// File: test/pinhole_world_to_image_top_test.sv
// self-checking testbench for the pinhole world to image projection block
`timescale 1ns / 1ps
module pinhole_world_to_image_top_test;
   localparam int FracBits   = 16;
   localparam int Latency    = pwti_pkg::DivSteps + 5;
   localparam int StallLimit = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_ready;
   pwti_pkg::req_word_type req_word  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   pwti_pkg::rsp_word_type rsp_word;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [pwti_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [63:0]            csr_data = '0;

   pinhole_world_to_image_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // predictor copy of the six row registers
   logic [63:0] matrix_regs [pwti_pkg::NumRegs];

   pwti_pkg::req_word_type point_queue [$];
   pwti_pkg::rsp_word_type pixel_queue [$];

   int send_idle_pct = 0;   // sender gap percentage
   int recv_stall_pct = 0;  // receiver stall percentage
   int error_count = 0;
   int points_sent = 0;
   int pixels_seen = 0;
   int zero_depth_seen = 0;
   int saturated_seen = 0;
   int quiet_cycles = 0;

   // signed coefficient k of row r
   function automatic longint coeff(int r, int k);
      logic [63:0] reg_val;
      reg_val = matrix_regs[r * 2 + k / 2];
      return longint'($signed(k % 2 ? reg_val[63:32] : reg_val[31:0]));
   endfunction

   // one row of P times (x, y, z, 1); arithmetic shift floors each product
   function automatic longint row_sum(int r, pwti_pkg::req_word_type pt);
      longint acc;
      acc = (coeff(r, 0) * longint'(pt.world_x)) >>> FracBits;
      acc += (coeff(r, 1) * longint'(pt.world_y)) >>> FracBits;
      acc += (coeff(r, 2) * longint'(pt.world_z)) >>> FracBits;
      return acc + coeff(r, 3);
   endfunction

   // fixed point quotient truncated toward zero, saturating to 32 bits
   function automatic logic [31:0] pixel_divide(longint num, longint den,
                                                inout logic sat);
      logic        neg;
      logic [63:0] n_mag, d_mag, q, r, max_mag;
      neg = (num < 0) != (den < 0);
      n_mag = num < 0 ? 64'(-num) : 64'(num);
      d_mag = den < 0 ? 64'(-den) : 64'(den);
      q = n_mag / d_mag;
      r = n_mag % d_mag;
      max_mag = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (q > (64'd1 << (31 - FracBits))) begin
         sat = 1'b1;
         return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      for (int i = 0; i < FracBits; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d_mag) begin
            r -= d_mag;
            q[0] = 1'b1;
         end
      end
      if (q > max_mag) begin
         sat = 1'b1;
         return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      return neg ? 32'(-q) : q[31:0];
   endfunction

   function automatic pwti_pkg::rsp_word_type project_point(pwti_pkg::req_word_type pt);
      pwti_pkg::rsp_word_type res;
      longint                 nu, nv, dz;
      logic                   sat;
      sat = 1'b0;
      nu = row_sum(0, pt);
      nv = row_sum(1, pt);
      dz = row_sum(2, pt);
      if (dz == 0) begin
         res.pixel_u = '0;
         res.pixel_v = '0;
         res.status = pwti_pkg::StatusZeroDepth;
      end else begin
         res.pixel_u = pixel_divide(nu, dz, sat);
         res.pixel_v = pixel_divide(nv, dz, sat);
         res.status = sat ? pwti_pkg::StatusSaturated : pwti_pkg::StatusOk;
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // driver: keeps valid up until the word is taken, random gaps otherwise
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            pixel_queue.push_back(project_point(req_word));
            points_sent++;
         end
         if (!req_valid || req_ready) begin
            if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_word <= point_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back pressure, compares each word with oldest prediction
   always @(posedge clock) begin
      pwti_pkg::rsp_word_type want;
      if (!reset) begin
         rsp_ready <= $urandom_range(99) >= recv_stall_pct;
         if (rsp_valid && rsp_ready) begin
            pixels_seen++;
            if (pixel_queue.size() == 0) begin
               $display("unexpected word %h", rsp_word);
               error_count++;
            end else begin
               want = pixel_queue.pop_front();
               if (rsp_word.pixel_u !== want.pixel_u)
                  report_mismatch("pixel_u", rsp_word.pixel_u, want.pixel_u);
               if (rsp_word.pixel_v !== want.pixel_v)
                  report_mismatch("pixel_v", rsp_word.pixel_v, want.pixel_v);
               if (rsp_word.status !== want.status)
                  report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
               if (want.status == pwti_pkg::StatusZeroDepth) zero_depth_seen++;
               if (want.status == pwti_pkg::StatusSaturated) saturated_seen++;
            end
         end
      end
   end

   // watchdog: any cycle without a handshake counts toward the limit
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
         $display("watchdog timeout");
         $display("pinhole_world_to_image_top_test NOT OK");
         $finish;
      end
   end

   task automatic write_reg(int idx, logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx[pwti_pkg::CsrIdxWidth-1:0];
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < pwti_pkg::NumRegs) matrix_regs[idx] = value;
   endtask

   // wait for every prediction to be matched, then let the pipe drain
   task automatic drain();
      while (point_queue.size() > 0 || req_valid || pixel_queue.size() > 0)
         @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom;
         default: return 32'($signed($urandom_range(20 << 16))) - (32'd10 << 16);
      endcase
   endfunction

   function automatic pwti_pkg::req_word_type rand_point();
      pwti_pkg::req_word_type pt;
      pt.world_x = rand_coord();
      pt.world_y = rand_coord();
      pt.world_z = rand_coord();
      return pt;
   endfunction

   function automatic logic [31:0] rand_coeff(int big);
      if (big != 0) return $urandom;
      return 32'($signed($urandom_range(8 << 16))) - (32'd4 << 16);
   endfunction

   task automatic load_matrix(int big);
      for (int i = 0; i < pwti_pkg::NumRegs; i++)
         write_reg(i, {rand_coeff(big), rand_coeff(big)});
   endtask

   // directed points: extremes and the depth-zero and saturation cases
   task automatic queue_directed();
      point_queue.push_back('{32'sh0, 32'sh0, 32'sh0});
      point_queue.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
      point_queue.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
      point_queue.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1_0000});
      point_queue.push_back('{32'sh1_0000, 32'sh2_0000, 32'sh3_0000});
      point_queue.push_back('{-32'sh1_0000, 32'sh0, 32'sh1});
      point_queue.push_back('{32'shFFFF_FFFF, 32'sh1, 32'sh5_0000});
   endtask

   task automatic run_phase(int count, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) point_queue.push_back(rand_point());
      drain();
   endtask

   initial begin
      for (int i = 0; i < pwti_pkg::NumRegs; i++) matrix_regs[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // all-zero matrix after reset: every point has zero depth
      queue_directed();
      drain();

      // identity-like camera: u = x/z, v = y/z
      write_reg(0, {32'h0, 32'h1_0000});
      write_reg(1, {32'h0, 32'h0});
      write_reg(2, {32'h1_0000, 32'h0});
      write_reg(3, {32'h0, 32'h0});
      write_reg(4, {32'h0, 32'h0});
      write_reg(5, {32'h0, 32'h1_0000});
      write_reg(7, 64'hFFFF_FFFF_FFFF_FFFF);   // out-of-range index, ignored
      queue_directed();
      point_queue.push_back('{32'sh10_0000, 32'sh0, 32'sh1});    // saturates
      point_queue.push_back('{32'sh1_0000, -32'sh1_0000, 32'sh0}); // zero depth
      drain();

      // extreme coefficients
      for (int i = 0; i < pwti_pkg::NumRegs; i++) write_reg(i, 64'h8000_0000_7FFF_FFFF);
      queue_directed();
      drain();

      load_matrix(0);
      run_phase(100, 0, 0);
      load_matrix(1);
      run_phase(100, 50, 0);
      load_matrix(0);
      run_phase(100, 0, 50);
      for (int i = 0; i < pwti_pkg::NumRegs; i++) write_reg(i, 64'hFFFF_FFFF_FFFF_FFFF);
      run_phase(50, 10, 10);
      load_matrix(0);
      run_phase(50, 10, 10);

      $display("sent %0d points, checked %0d pixels", points_sent, pixels_seen);
      $display("zero depth %0d, saturated %0d, over directed, random and extreme matrices",
               zero_depth_seen, saturated_seen);
      if (error_count == 0 && pixel_queue.size() == 0)
         $display("pinhole_world_to_image_top_test OK");
      else
         $display("pinhole_world_to_image_top_test NOT OK");
      $finish;
   end
endmodule

// File: sim.f
design/pwti_pkg.sv
design/pwti_dot.sv
design/pwti_div_cell.sv
design/pinhole_world_to_image_top.sv
test/pinhole_world_to_image_top_test.sv
